### hdl/lpru_pkg.sv
`timescale 1ns / 1ps

package lpru_pkg;

    // Default sizes of the ring and of the fraction compare.
    localparam int SITES_DEF     = 128;
    localparam int DRAW_BITS_DEF = 16;

    // Fixed field widths.
    localparam int SITE_W    = 7;
    localparam int DRAW_W    = 16;
    localparam int PROB_W    = 16;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CODE_W    = 4;

    // Operation codes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd2;

    // Threshold values after reset.
    localparam logic [PROB_W-1:0] PROB_ALPHA_RST = 16'd9726;
    localparam logic [PROB_W-1:0] PROB_BETA_RST  = 16'd1311;
    localparam logic [PROB_W-1:0] PROB_GAMMA_RST = 16'd58982;

    // Which threshold a pair code is tested against.
    localparam logic [1:0] TEST_NONE  = 2'd0;
    localparam logic [1:0] TEST_ALPHA = 2'd1;
    localparam logic [1:0] TEST_BETA  = 2'd2;
    localparam logic [1:0] TEST_GAMMA = 2'd3;

    // The pair code that retries on the second draw, and where it goes then.
    localparam logic [CODE_W-1:0] CODE_FALLBACK_SRC = 4'd11;
    localparam logic [CODE_W-1:0] CODE_FALLBACK_DST = 4'd8;

    typedef struct packed {
        logic [PROB_W-1:0] alpha;
        logic [PROB_W-1:0] beta;
        logic [PROB_W-1:0] gamma;
    } t_thresholds;

    // Threshold selection per pair code {A[i], A[j], B[i], B[j]}.
    function automatic logic [1:0] test_of_code(input logic [CODE_W-1:0] code);
        logic [1:0] test;
        case (code)
            4'd3, 4'd7, 4'd15:        test = TEST_BETA;
            4'd6, 4'd14:              test = TEST_GAMMA;
            4'd8, 4'd9, 4'd10, 4'd11: test = TEST_ALPHA;
            default:                  test = TEST_NONE;
        endcase
        return test;
    endfunction

    // Pair code written when the first test succeeds.
    function automatic logic [CODE_W-1:0] next_of_code(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] nxt;
        case (code)
            4'd3:    nxt = 4'd0;
            4'd6:    nxt = 4'd3;
            4'd7:    nxt = 4'd4;
            4'd8:    nxt = 4'd12;
            4'd9:    nxt = 4'd13;
            4'd10:   nxt = 4'd14;
            4'd11:   nxt = 4'd15;
            4'd14:   nxt = 4'd11;
            4'd15:   nxt = 4'd12;
            default: nxt = code;
        endcase
        return nxt;
    endfunction

endpackage

### hdl/lpru_rule.sv
`timescale 1ns / 1ps

module lpru_rule
    import lpru_pkg::*;
#(
    parameter int DRAW_BITS = DRAW_BITS_DEF
) (
    input  logic [CODE_W-1:0] i_code,
    input  logic [DRAW_W-1:0] i_draw_one,
    input  logic [DRAW_W-1:0] i_draw_two,
    input  t_thresholds       i_thr,
    output logic [CODE_W-1:0] o_next
);

    // Only the low DRAW_BITS bits of draws and thresholds take part.
    localparam logic [63:0] MASK64 = (64'd1 << DRAW_BITS) - 64'd1;
    localparam logic [31:0] MASK   = MASK64[31:0];

    logic [1:0]        w_test;
    logic [PROB_W-1:0] w_thr;
    logic              w_pass_one;
    logic              w_pass_two;

    // Pick the threshold for this code.
    always_comb begin
        w_test = test_of_code(i_code);
        case (w_test)
            TEST_ALPHA: w_thr = i_thr.alpha;
            TEST_BETA:  w_thr = i_thr.beta;
            default:    w_thr = i_thr.gamma;
        endcase
    end

    // Strict compares: the draw must lie below the threshold.
    assign w_pass_one = (32'(i_draw_one) & MASK) < (32'(w_thr) & MASK);
    assign w_pass_two = (32'(i_draw_two) & MASK) < (32'(i_thr.beta) & MASK);

    // New pair code, with the second-draw retry for the fallback code.
    always_comb begin
        o_next = i_code;
        if (w_test != TEST_NONE) begin
            if (w_pass_one) begin
                o_next = next_of_code(i_code);
            end else if (i_code == CODE_FALLBACK_SRC && w_pass_two) begin
                o_next = CODE_FALLBACK_DST;
            end
        end
    end

endmodule

### hdl/lattice_pair_reaction_update_top.sv
`timescale 1ns / 1ps
// Pair-reaction update engine for a ring of SITES sites, two bits per site.
// Command channel: a word (opcode, site, load bits, two draws) is taken at
// a rising edge where i_start is high and o_busy is low. Opcode load writes
// one site's A and B bits; opcode update tests the pair (site, site + 1 mod
// SITES) against the alpha, beta or gamma threshold and may rewrite it.
// Configuration channel: i_cfg_valid / o_cfg_ready with a register index
// (0 alpha, 1 beta, 2 gamma) and 16-bit data; other indexes are ignored.
// Write it only while no word is in flight.
// Result: o_done is high for exactly one cycle per word, with the A and B
// counts after the word and o_pair_changed. The word passes the input register
// and then the result register, which raises the strobe; the receiver cannot
// hold it off.
// Throughput is one word per cycle while o_busy is low: the site bits live in
// flip-flops, so the read-modify-write of the pair and the count update are
// combinational between the input register and the result register.
// Reset (synchronous, active low) clears all site bits and counts, restores
// the default thresholds and drops any word in flight; o_busy is high during
// reset and is cleared by its register once reset is released.
module lattice_pair_reaction_update_top
    import lpru_pkg::*;
#(
    parameter int SITES     = SITES_DEF,
    parameter int DRAW_BITS = DRAW_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_opcode,
    input  logic [SITE_W-1:0]    i_site,
    input  logic                 i_load_species_a,
    input  logic                 i_load_species_b,
    input  logic [DRAW_W-1:0]    i_draw_one,
    input  logic [DRAW_W-1:0]    i_draw_two,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PROB_W-1:0]    i_cfg_data,
    output logic                 o_done,
    output logic [COUNT_W-1:0]   o_count_species_a,
    output logic [COUNT_W-1:0]   o_count_species_b,
    output logic                 o_pair_changed
);

    localparam int IDX_W = (SITES > 1) ? $clog2(SITES) : 1;

    // Control and state registers.
    logic               r_busy;
    logic               r_in_valid;
    logic               r_out_valid;
    logic [SITES-1:0]   r_sites_a;
    logic [SITES-1:0]   r_sites_b;
    logic [COUNT_W-1:0] r_count_a;
    logic [COUNT_W-1:0] r_count_b;
    t_thresholds        r_thr;

    // Input word register.
    logic               r_op;
    logic [SITE_W-1:0]  r_site;
    logic               r_load_a;
    logic               r_load_b;
    logic [DRAW_W-1:0]  r_draw_one;
    logic [DRAW_W-1:0]  r_draw_two;

    // Result register.
    logic [COUNT_W-1:0] r_res_count_a;
    logic [COUNT_W-1:0] r_res_count_b;
    logic               r_res_changed;

    logic [31:0]        w_site_ext;
    logic               w_in_range;
    logic [IDX_W-1:0]   w_i;
    logic [IDX_W-1:0]   w_j;
    logic               w_a_i;
    logic               w_a_j;
    logic               w_b_i;
    logic               w_b_j;
    logic [CODE_W-1:0]  w_next;
    logic               w_accept;

    logic               n_a_i;
    logic               n_a_j;
    logic               n_b_i;
    logic               n_b_j;
    logic [COUNT_W-1:0] n_count_a;
    logic [COUNT_W-1:0] n_count_b;
    logic               n_changed;

    assign w_accept = i_start && !r_busy;

    // Site addressing: the pair wraps from the last site to site 0.
    assign w_site_ext = 32'(r_site);
    assign w_in_range = w_site_ext < 32'(SITES);
    assign w_i        = w_site_ext[IDX_W-1:0];
    assign w_j        = (w_i == IDX_W'(SITES - 1)) ? '0 : w_i + IDX_W'(1);

    assign w_a_i = r_sites_a[w_i];
    assign w_a_j = r_sites_a[w_j];
    assign w_b_i = r_sites_b[w_i];
    assign w_b_j = r_sites_b[w_j];

    lpru_rule #(
        .DRAW_BITS (DRAW_BITS)
    ) u_rule (
        .i_code     ({w_a_i, w_a_j, w_b_i, w_b_j}),
        .i_draw_one (r_draw_one),
        .i_draw_two (r_draw_two),
        .i_thr      (r_thr),
        .o_next     (w_next)
    );

    // New bits of the pair; a load leaves the neighbor as it is.
    always_comb begin
        if (r_op == OP_LOAD) begin
            n_a_i = r_load_a;
            n_b_i = r_load_b;
            n_a_j = w_a_j;
            n_b_j = w_b_j;
        end else begin
            n_a_i = w_next[3];
            n_a_j = w_next[2];
            n_b_i = w_next[1];
            n_b_j = w_next[0];
        end
    end

    // Counts follow the bit changes, modulo 256.
    assign n_count_a = r_count_a - COUNT_W'(w_a_i) - COUNT_W'(w_a_j)
                     + COUNT_W'(n_a_i) + COUNT_W'(n_a_j);
    assign n_count_b = r_count_b - COUNT_W'(w_b_i) - COUNT_W'(w_b_j)
                     + COUNT_W'(n_b_i) + COUNT_W'(n_b_j);
    assign n_changed = w_in_range && ((w_a_i != n_a_i) || (w_a_j != n_a_j)
                                   || (w_b_i != n_b_i) || (w_b_j != n_b_j));

    // Control, site state, counts and thresholds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sites_a   <= '0;
            r_sites_b   <= '0;
            r_count_a   <= '0;
            r_count_b   <= '0;
            r_thr.alpha <= PROB_ALPHA_RST;
            r_thr.beta  <= PROB_BETA_RST;
            r_thr.gamma <= PROB_GAMMA_RST;
        end else begin
            r_busy      <= 1'b0;
            r_in_valid  <= w_accept;
            r_out_valid <= r_in_valid;
            if (i_cfg_valid && !r_busy) begin
                case (i_cfg_index)
                    CFG_ALPHA: r_thr.alpha <= i_cfg_data;
                    CFG_BETA:  r_thr.beta  <= i_cfg_data;
                    CFG_GAMMA: r_thr.gamma <= i_cfg_data;
                    default:   ;
                endcase
            end
            if (r_in_valid && w_in_range) begin
                r_sites_a[w_i] <= n_a_i;
                r_sites_b[w_i] <= n_b_i;
                r_sites_a[w_j] <= n_a_j;
                r_sites_b[w_j] <= n_b_j;
                r_count_a      <= n_count_a;
                r_count_b      <= n_count_b;
            end
        end
    end

    // Input word capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_opcode;
            r_site     <= i_site;
            r_load_a   <= i_load_species_a;
            r_load_b   <= i_load_species_b;
            r_draw_one <= i_draw_one;
            r_draw_two <= i_draw_two;
        end
    end

    // Result capture; an out-of-range site reports the counts unchanged.
    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_res_count_a <= w_in_range ? n_count_a : r_count_a;
            r_res_count_b <= w_in_range ? n_count_b : r_count_b;
            r_res_changed <= n_changed;
        end
    end

    assign o_busy            = r_busy;
    assign o_cfg_ready       = !r_busy;
    assign o_done            = r_out_valid;
    assign o_count_species_a = r_res_count_a;
    assign o_count_species_b = r_res_count_b;
    assign o_pair_changed    = r_res_changed;

`ifndef SYNTHESIS
    // Every accepted word gives its result once it has passed the input register and the result register.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##2 o_done)
        else $error("accepted word produced no result");

    // No result without a word in the input register the cycle before.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_in_valid))
        else $error("result strobe without a word");

    // A word that changed nothing leaves the reported counts as they were.
    a_unchanged_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_pair_changed) |->
            (o_count_species_a == $past(r_count_a))
            && (o_count_species_b == $past(r_count_b)))
        else $error("counts moved without a change");

    // Counts never exceed the number of sites on small rings.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (SITES > 255)
            || ((32'(o_count_species_a) <= 32'(SITES))
                && (32'(o_count_species_b) <= 32'(SITES))))
        else $error("count above ring size");
`endif

endmodule
